/* src/pbu_pkg.sv */
`default_nettype none
package pbu_pkg;

	// Vector geometry
	localparam int POLY_COUNT      = 3;
	localparam int COEFFS_PER_POLY = 256;

	// Field and state widths
	localparam int BYTE_W   = 8;
	localparam int COEF_W   = 13;
	localparam int NARROW_W = 10;
	localparam int POLY_W   = 2;
	localparam int CIDX_W   = 8;
	localparam int BUF_W    = 20;
	localparam int FILL_W   = 5;
	localparam int OUT_W    = 24;

	// Terminal counter values
	localparam logic [CIDX_W-1:0] LAST_COEFF = CIDX_W'(COEFFS_PER_POLY - 1);
	localparam logic [POLY_W-1:0] LAST_POLY  = POLY_W'(POLY_COUNT - 1);

	// Coefficient width selector
	typedef enum logic {
		MODE_10BIT = 1'b0,
		MODE_13BIT = 1'b1
	} width_mode_t;

	// One unpacked coefficient with its position
	typedef struct packed {
		logic              last;
		logic [CIDX_W-1:0] coeff_index;
		logic [POLY_W-1:0] poly_index;
		logic [COEF_W-1:0] coefficient;
	} result_t;

endpackage
`default_nettype wire

/* src/polyvec_bit_unpacker_top.sv */
`default_nettype none
// Polynomial vector bit unpacker. Takes one packed byte per request on the
// s_axis side, joins the bits least significant first and gives out one
// coefficient of 10 bits (cfg_wdata = 0) or 13 bits (cfg_wdata = 1) on the
// m_axis side as soon as enough bits are held, with its polynomial and
// coefficient index; tlast marks the final coefficient of the vector, after
// which leftover bits are dropped and the counters restart. One byte is
// accepted every cycle while the result register is empty or being emptied;
// the result is registered and appears in the cycle after the byte that
// completes it. Write the width mode only while the stream is idle.
module polyvec_bit_unpacker_top (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_wen,
	input  wire  [0:0]  cfg_wdata,
	// byte stream in
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	// coefficient stream out
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [12:0] coefficient, [14:13] poly_index,
	                                    // [22:15] coeff_index, [23] zero
	output logic        m_axis_tlast    // last_of_vector
);

	pbu_pkg::width_mode_t               mode_q;
	logic [pbu_pkg::BUF_W-1:0]          buf_q;
	logic [pbu_pkg::FILL_W-1:0]         fill_q;
	logic [pbu_pkg::CIDX_W-1:0]         cidx_q;
	logic [pbu_pkg::POLY_W-1:0]         pidx_q;
	logic                               out_valid_q;
	pbu_pkg::result_t                   out_q;

	logic                               in_acc;
	logic [pbu_pkg::BUF_W-1:0]          buf_join;
	logic [pbu_pkg::FILL_W-1:0]         fill_join;
	logic [pbu_pkg::FILL_W-1:0]         width;
	logic                               emit;
	logic [pbu_pkg::COEF_W-1:0]         coef;
	logic [pbu_pkg::BUF_W-1:0]          buf_rest;
	logic                               last_coef;
	logic                               last_poly;

	// Accept a byte whenever the result register is free this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Append the byte above the held bits and cut off one coefficient
	always_comb begin
		buf_join  = buf_q | ({{(pbu_pkg::BUF_W - pbu_pkg::BYTE_W){1'b0}}, s_axis_tdata}
		            << fill_q);
		fill_join = fill_q + pbu_pkg::FILL_W'(pbu_pkg::BYTE_W);
		case (mode_q)
			pbu_pkg::MODE_13BIT: begin
				width    = pbu_pkg::FILL_W'(pbu_pkg::COEF_W);
				coef     = buf_join[pbu_pkg::COEF_W-1:0];
				buf_rest = buf_join >> pbu_pkg::COEF_W;
			end
			default: begin
				width    = pbu_pkg::FILL_W'(pbu_pkg::NARROW_W);
				coef     = {{(pbu_pkg::COEF_W - pbu_pkg::NARROW_W){1'b0}},
				            buf_join[pbu_pkg::NARROW_W-1:0]};
				buf_rest = buf_join >> pbu_pkg::NARROW_W;
			end
		endcase
		emit      = fill_join >= width;
		last_coef = cidx_q == pbu_pkg::LAST_COEFF;
		last_poly = pidx_q == pbu_pkg::LAST_POLY;
	end

	// Hold the width mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pbu_pkg::MODE_10BIT;
		end else if (cfg_wen) begin
			mode_q <= pbu_pkg::width_mode_t'(cfg_wdata[0]);
		end
	end

	// Advance buffer and counters on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			fill_q <= '0;
			cidx_q <= '0;
			pidx_q <= '0;
		end else if (in_acc) begin
			if (!emit) begin
				buf_q  <= buf_join;
				fill_q <= fill_join;
			end else if (last_coef && last_poly) begin
				buf_q  <= '0;
				fill_q <= '0;
				cidx_q <= '0;
				pidx_q <= '0;
			end else begin
				buf_q  <= buf_rest;
				fill_q <= fill_join - width;
				if (last_coef) begin
					cidx_q <= '0;
					pidx_q <= pidx_q + pbu_pkg::POLY_W'(1);
				end else begin
					cidx_q <= cidx_q + pbu_pkg::CIDX_W'(1);
				end
			end
		end
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_q.coefficient <= coef;
			out_q.poly_index  <= pidx_q;
			out_q.coeff_index <= cidx_q;
			out_q.last        <= last_coef && last_poly;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.coeff_index, out_q.poly_index, out_q.coefficient};
	assign m_axis_tlast  = out_q.last;

	// The bit buffer never holds more bits than it has room for
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pbu_pkg::FILL_W'(pbu_pkg::BUF_W))
		else $error("bit fill beyond buffer size");

	// A stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast)))
		else $error("stalled result changed");

	// The vector end flag comes only with the final indices
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_q.coeff_index == pbu_pkg::LAST_COEFF
		&& out_q.poly_index == pbu_pkg::LAST_POLY))
		else $error("last flag on wrong coefficient");

	// Counters restart after the final coefficient of a vector
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && emit && last_coef && last_poly) |=> (fill_q == '0 && cidx_q == '0
		&& pidx_q == '0))
		else $error("counters not cleared at end of vector");

endmodule
`default_nettype wire
